// File: design/bfla_pkg.sv
`timescale 1ns / 1ps

package bfla_pkg;

  // field widths of the item, result and config ports
  localparam int unsigned IDX_W = 12;
  localparam int unsigned CNT_W = 13;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned MAX_BLOCKS_DEFAULT = 4096;
  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 13'd4096;

  typedef enum logic {
    OPC_ACQUIRE = 1'b0,
    OPC_RELEASE = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_GRANTED  = 2'd0,
    STATUS_RELEASED = 2'd1,
    STATUS_OOM      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LINK
  } state_e;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_OOM,
    OP_BUMP,
    OP_POP_READ,
    OP_POP_FINISH,
    OP_REL_TAKE,
    OP_REL_CLOSE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   emit;
  } dp_cmd_t;

  typedef struct packed {
    logic oom;
    logic list_nonempty;
  } dp_sts_t;

  // one link entry: end-of-list mark and next index
  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] next;
  } link_entry_t;

endpackage

// File: design/bfla_ram.sv
`timescale 1ns / 1ps

module bfla_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/bfla_ctrl.sv
`timescale 1ns / 1ps

module bfla_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              opcode_i,
  input  logic              batch_last_i,
  input  bfla_pkg::dp_sts_t sts_i,
  output bfla_pkg::dp_cmd_t cmd_o,
  output logic              busy
);

  bfla_pkg::state_e state_q, state_d;
  logic is_release;

  assign is_release = (bfla_pkg::opcode_e'(opcode_i) == bfla_pkg::OPC_RELEASE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfla_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfla_pkg::S_IDLE: begin
        if (start) begin
          if (is_release && batch_last_i) begin
            state_d = bfla_pkg::S_LINK;
          end else if (!is_release && !sts_i.oom && sts_i.list_nonempty) begin
            state_d = bfla_pkg::S_POP;
          end
        end
      end
      bfla_pkg::S_POP:  state_d = bfla_pkg::S_IDLE;
      bfla_pkg::S_LINK: state_d = bfla_pkg::S_IDLE;
      default:          state_d = bfla_pkg::S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd_o.op   = bfla_pkg::OP_IDLE;
    cmd_o.emit = 1'b0;
    unique case (state_q)
      bfla_pkg::S_IDLE: begin
        if (start) begin
          if (is_release) begin
            cmd_o.op   = bfla_pkg::OP_REL_TAKE;
            cmd_o.emit = !batch_last_i;
          end else if (sts_i.oom) begin
            cmd_o.op   = bfla_pkg::OP_OOM;
            cmd_o.emit = 1'b1;
          end else if (sts_i.list_nonempty) begin
            cmd_o.op = bfla_pkg::OP_POP_READ;
          end else begin
            cmd_o.op   = bfla_pkg::OP_BUMP;
            cmd_o.emit = 1'b1;
          end
        end
      end
      bfla_pkg::S_POP: begin
        cmd_o.op   = bfla_pkg::OP_POP_FINISH;
        cmd_o.emit = 1'b1;
      end
      bfla_pkg::S_LINK: begin
        cmd_o.op   = bfla_pkg::OP_REL_CLOSE;
        cmd_o.emit = 1'b1;
      end
      default: begin
        cmd_o.op   = bfla_pkg::OP_IDLE;
        cmd_o.emit = 1'b0;
      end
    endcase
  end

  assign busy = (state_q != bfla_pkg::S_IDLE);

endmodule

// File: design/bfla_datapath.sv
`timescale 1ns / 1ps

module bfla_datapath #(
  parameter int unsigned MAX_BLOCKS = bfla_pkg::MAX_BLOCKS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfla_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic [bfla_pkg::IDX_W-1:0]    released_index_i,
  input  bfla_pkg::dp_cmd_t             cmd_i,
  output bfla_pkg::dp_sts_t             sts_o,
  output logic                          done_o,
  output logic [bfla_pkg::IDX_W-1:0]    granted_index_o,
  output logic [bfla_pkg::STATUS_W-1:0] status_o
);

  localparam int unsigned IdxW  = bfla_pkg::IDX_W;
  localparam int unsigned CntW  = bfla_pkg::CNT_W;
  localparam int unsigned AddrW = $clog2(MAX_BLOCKS);
  localparam int unsigned LinkW = $bits(bfla_pkg::link_entry_t);
  localparam logic [CntW-1:0] LimCap =
    (MAX_BLOCKS >= (1 << CntW) - 1) ? {CntW{1'b1}} : CntW'(MAX_BLOCKS);

  logic [CntW-1:0] block_count_q;
  logic [IdxW-1:0] list_head_q, list_head_d;
  logic            list_nonempty_q, list_nonempty_d;
  logic [CntW-1:0] bump_next_q, bump_next_d;
  logic [IdxW-1:0] chain_first_q, chain_first_d;
  logic [IdxW-1:0] chain_tail_q, chain_tail_d;
  logic            chain_open_q, chain_open_d;
  logic            done_q;
  logic [IdxW-1:0] granted_q, granted_d;
  bfla_pkg::status_e status_q, status_d;

  logic [CntW-1:0] limit;
  logic [CntW-1:0] cand;
  logic [IdxW-1:0] rel_red;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  bfla_pkg::link_entry_t ram_wdata;
  logic               ram_re;
  bfla_pkg::link_entry_t ram_rdata;
  logic [LinkW-1:0]   ram_rdata_raw;

  // usable limit and out-of-memory check
  assign limit = (block_count_q > LimCap) ? LimCap : block_count_q;
  assign cand  = list_nonempty_q ? {1'b0, list_head_q} : bump_next_q;
  assign sts_o.oom           = (cand >= limit);
  assign sts_o.list_nonempty = list_nonempty_q;

  // released index reduced into the store range by constant compare-subtract
  always_comb begin
    logic [IdxW:0] sub;
    sub     = '0;
    rel_red = released_index_i;
    for (int k = IdxW - 1; k >= 0; k--) begin
      if ((MAX_BLOCKS << k) < (1 << IdxW)) begin
        sub = (IdxW + 1)'(MAX_BLOCKS << k);
        if ({1'b0, rel_red} >= sub) begin
          rel_red = rel_red - sub[IdxW-1:0];
        end
      end
    end
  end

  // link store
  bfla_ram #(
    .WIDTH (LinkW),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (AddrW'(list_head_q)),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = bfla_pkg::link_entry_t'(ram_rdata_raw);
  assign ram_re    = (cmd_i.op == bfla_pkg::OP_POP_READ);
  assign ram_waddr = AddrW'(chain_tail_q);

  // link writes: chain extension and batch close
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (cmd_i.op == bfla_pkg::OP_REL_TAKE && chain_open_q) begin
      ram_we         = 1'b1;
      ram_wdata.last = 1'b0;
      ram_wdata.next = rel_red;
    end else if (cmd_i.op == bfla_pkg::OP_REL_CLOSE) begin
      ram_we         = 1'b1;
      ram_wdata.last = !list_nonempty_q;
      ram_wdata.next = list_head_q;
    end
  end

  // allocator state and result update
  always_comb begin
    list_head_d     = list_head_q;
    list_nonempty_d = list_nonempty_q;
    bump_next_d     = bump_next_q;
    chain_first_d   = chain_first_q;
    chain_tail_d    = chain_tail_q;
    chain_open_d    = chain_open_q;
    granted_d       = '0;
    status_d        = bfla_pkg::STATUS_GRANTED;
    unique case (cmd_i.op)
      bfla_pkg::OP_OOM: begin
        status_d = bfla_pkg::STATUS_OOM;
      end
      bfla_pkg::OP_BUMP: begin
        granted_d   = bump_next_q[IdxW-1:0];
        bump_next_d = bump_next_q + 1'b1;
      end
      bfla_pkg::OP_POP_FINISH: begin
        granted_d       = list_head_q;
        list_head_d     = ram_rdata.next;
        list_nonempty_d = !ram_rdata.last;
      end
      bfla_pkg::OP_REL_TAKE: begin
        status_d = bfla_pkg::STATUS_RELEASED;
        if (!chain_open_q) begin
          chain_first_d = rel_red;
        end
        chain_tail_d = rel_red;
        chain_open_d = 1'b1;
      end
      bfla_pkg::OP_REL_CLOSE: begin
        status_d        = bfla_pkg::STATUS_RELEASED;
        list_head_d     = chain_first_q;
        list_nonempty_d = 1'b1;
        chain_open_d    = 1'b0;
      end
      default: begin
        status_d = bfla_pkg::STATUS_GRANTED;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q   <= bfla_pkg::BLOCK_COUNT_RST;
      list_head_q     <= '0;
      list_nonempty_q <= 1'b0;
      bump_next_q     <= '0;
      chain_first_q   <= '0;
      chain_tail_q    <= '0;
      chain_open_q    <= 1'b0;
      done_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        block_count_q <= cfg_wdata_i;
      end
      list_head_q     <= list_head_d;
      list_nonempty_q <= list_nonempty_d;
      bump_next_q     <= bump_next_d;
      chain_first_q   <= chain_first_d;
      chain_tail_q    <= chain_tail_d;
      chain_open_q    <= chain_open_d;
      done_q          <= cmd_i.emit;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      granted_q <= granted_d;
      status_q  <= status_d;
    end
  end

  assign done_o          = done_q;
  assign granted_index_o = granted_q;
  assign status_o        = status_q;

endmodule

// File: design/block_free_list_allocator_unit.sv
`timescale 1ns / 1ps

// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+------------------------------
// item in   | opcode_i, released_index_i, batch_last_i      | taken when start && !busy
// result    | granted_index_o, status_o                     | valid for one cycle on done_o
// config    | cfg_wdata_i (block_count)                     | written when cfg_we_i
//
// an acquire served by the bump counter, an out-of-memory acquire and a release
// that does not close its batch finish in the cycle they are taken; a pop from the
// free list and a batch-closing release also pass through S_POP or S_LINK, set by
// the registered read and the single write port of the link memory. the result
// is registered and appears the cycle after the item finishes. reset empties the
// free list and clears the bump counter; the link memory needs no clearing. the receiver cannot stall the result.

module block_free_list_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = bfla_pkg::MAX_BLOCKS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfla_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode_i,
  input  logic [bfla_pkg::IDX_W-1:0]    released_index_i,
  input  logic                          batch_last_i,
  output logic                          done_o,
  output logic [bfla_pkg::IDX_W-1:0]    granted_index_o,
  output logic [bfla_pkg::STATUS_W-1:0] status_o
);

  bfla_pkg::dp_cmd_t cmd;
  bfla_pkg::dp_sts_t sts;
  logic              start_ok;

  // no item enters while the controller is mid-operation
  assign start_ok = start && !busy;

  // controller
  bfla_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start_ok),
    .opcode_i     (opcode_i),
    .batch_last_i (batch_last_i),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy         (busy)
  );

  // datapath with link memory
  bfla_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .released_index_i (released_index_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .done_o           (done_o),
    .granted_index_o  (granted_index_o),
    .status_o         (status_o)
  );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bfla_pkg::*;

  localparam int unsigned NUM_BLOCKS = MAX_BLOCKS_DEFAULT;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    status_e          status;
  } alloc_result_t;

  // free list shadow: predicts every result and holds the ones still awaited
  class free_list_scoreboard;
    logic [CNT_W-1:0] block_count;
    logic [IDX_W-1:0] link_next [NUM_BLOCKS];
    bit               link_end [NUM_BLOCKS];
    bit               link_set [NUM_BLOCKS];
    logic [IDX_W-1:0] head;
    bit               listed;
    logic [CNT_W-1:0] bump;
    logic [IDX_W-1:0] chain_first;
    logic [IDX_W-1:0] chain_tail;
    bit               chain_open;
    alloc_result_t    awaited_results[$];
    int               errors;
    int               grants;
    int               releases;
    int               ooms;

    function new();
      block_count = BLOCK_COUNT_RST;
      head = '0;
      listed = 1'b0;
      bump = '0;
      chain_first = '0;
      chain_tail = '0;
      chain_open = 1'b0;
      errors = 0;
      grants = 0;
      releases = 0;
      ooms = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function logic [CNT_W-1:0] usable_blocks();
      return (block_count > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : block_count;
    endfunction

    // a pop of the current head would read a link that was never written
    function bit pop_unlinked();
      return listed && !link_set[head];
    endfunction

    // accepted item: update the shadow state and queue the expected result
    function alloc_result_t predict_alloc(opcode_e op, logic [IDX_W-1:0] idx, logic last);
      alloc_result_t    res;
      logic [CNT_W-1:0] cand;
      res.index = '0;
      if (op == OPC_ACQUIRE) begin
        cand = listed ? {1'b0, head} : bump;
        if (cand >= usable_blocks()) begin
          res.status = STATUS_OOM;
          ooms++;
        end else begin
          if (listed) begin
            listed = !link_end[head];
            head = link_next[head];
          end else begin
            bump = bump + 1'b1;
          end
          res.index = cand[IDX_W-1:0];
          res.status = STATUS_GRANTED;
          grants++;
        end
      end else begin
        if (!chain_open) begin
          chain_first = idx;
          chain_open = 1'b1;
        end else begin
          link_next[chain_tail] = idx;
          link_end[chain_tail] = 1'b0;
          link_set[chain_tail] = 1'b1;
        end
        chain_tail = idx;
        // closing item: splice the whole chain in front of the old head
        if (last) begin
          link_next[idx] = head;
          link_end[idx] = !listed;
          link_set[idx] = 1'b1;
          head = chain_first;
          listed = 1'b1;
          chain_open = 1'b0;
        end
        res.status = STATUS_RELEASED;
        releases++;
      end
      awaited_results.push_back(res);
      return res;
    endfunction

    // compare one result strobe against the oldest expectation
    task check_result(logic [IDX_W-1:0] granted, logic [STATUS_W-1:0] status);
      alloc_result_t exp;
      if (awaited_results.size() == 0) begin
        report($sformatf("result index %0d status %0d with nothing awaited", granted, status));
      end else begin
        exp = awaited_results.pop_front();
        if (status !== exp.status)
          report($sformatf("status %0d, expected %0d", status, exp.status));
        if (granted !== exp.index)
          report($sformatf("granted index %0d, expected %0d", granted, exp.index));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CNT_W-1:0]    cfg_wdata_i;
  logic                start;
  logic                busy;
  logic                opcode_i;
  logic [IDX_W-1:0]    released_index_i;
  logic                batch_last_i;
  logic                done_o;
  logic [IDX_W-1:0]    granted_index_o;
  logic [STATUS_W-1:0] status_o;

  free_list_scoreboard sb = new();
  logic [IDX_W-1:0]    held[$];
  logic [IDX_W-1:0]    last_freed;
  int                  idle_pct;
  int                  item_count;
  int                  cfg_writes;

  block_free_list_allocator_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .released_index_i (released_index_i),
    .batch_last_i     (batch_last_i),
    .done_o           (done_o),
    .granted_index_o  (granted_index_o),
    .status_o         (status_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) sb.check_result(granted_index_o, status_o);
  end

  // drive one item and wait until it is taken
  task automatic push_item(opcode_e op, logic [IDX_W-1:0] idx, logic last);
    alloc_result_t res;
    // never pop an entry whose link was never written: close the batch instead
    if (op == OPC_ACQUIRE && sb.pop_unlinked()) begin
      op = OPC_RELEASE;
      last = 1'b1;
    end
    opcode_i = op;
    released_index_i = idx;
    batch_last_i = last;
    start = 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    res = sb.predict_alloc(op, idx, last);
    if (res.status == STATUS_GRANTED) held.push_back(res.index);
    if (op == OPC_RELEASE) last_freed = idx;
    item_count++;
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic acquire();
    push_item(OPC_ACQUIRE, IDX_W'($urandom), 1'($urandom));
  endtask

  // hold off until every awaited result has arrived
  task automatic drain();
    start = 1'b0;
    while (sb.awaited_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_block_count(logic [CNT_W-1:0] value);
    cfg_wdata_i = value;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.block_count = value;
    cfg_writes++;
  endtask

  // acquires and batches of granted blocks coming back, plus foreign and double releases
  task automatic run_random(int count);
    int               sent;
    int               roll;
    int               k;
    int               j;
    logic             last;
    logic [IDX_W-1:0] pick;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        acquire();
        sent++;
      end else if (roll < 82 && held.size() > 0) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
          j = $urandom_range(0, held.size() - 1);
          pick = held[j];
          held.delete(j);
          last = (i == k - 1) || (held.size() == 0);
          push_item(OPC_RELEASE, pick, last);
          sent++;
          if (last) break;
          // acquire while the batch is still open
          if ($urandom_range(9) == 0) begin
            acquire();
            sent++;
          end
        end
      end else begin
        case ($urandom_range(2))
          0: push_item(OPC_RELEASE, IDX_W'($urandom), 1'($urandom));
          1: begin
            case ($urandom_range(3))
              0: pick = '0;
              1: pick = '1;
              2: pick = IDX_W'(sb.usable_blocks() - 1'b1);
              default: pick = IDX_W'(sb.usable_blocks());
            endcase
            push_item(OPC_RELEASE, pick, 1'($urandom));
          end
          default: push_item(OPC_RELEASE, last_freed, 1'b1);
        endcase
        sent++;
      end
    end
  endtask

  // stimulus
  initial begin
    logic [CNT_W-1:0] counts [8];
    int               idles [8];
    counts = '{13'd16, 13'd4096, 13'd1, 13'd300, 13'd8191, 13'd0, 13'd4095, 13'd64};
    idles = '{0, 70, 17, 0, 70, 17, 70, 0};
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    opcode_i = OPC_ACQUIRE;
    released_index_i = '0;
    batch_last_i = 1'b0;
    last_freed = '0;
    idle_pct = 0;
    item_count = 0;
    cfg_writes = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: bump grants, foreign release, open batch, double release
    push_item(OPC_ACQUIRE, '0, 1'b0);
    push_item(OPC_ACQUIRE, '1, 1'b1);
    push_item(OPC_ACQUIRE, '0, 1'b0);
    push_item(OPC_RELEASE, '1, 1'b1);
    push_item(OPC_ACQUIRE, '0, 1'b0);
    push_item(OPC_RELEASE, 12'd0, 1'b0);
    push_item(OPC_RELEASE, 12'd1, 1'b1);
    push_item(OPC_RELEASE, 12'd2, 1'b0);
    push_item(OPC_ACQUIRE, '0, 1'b0);
    push_item(OPC_RELEASE, 12'd5, 1'b1);
    repeat (4) push_item(OPC_ACQUIRE, '0, 1'b0);
    push_item(OPC_RELEASE, 12'd7, 1'b1);
    push_item(OPC_RELEASE, 12'd7, 1'b1);
    push_item(OPC_ACQUIRE, '0, 1'b0);
    push_item(OPC_ACQUIRE, '0, 1'b0);
    // out of memory with a one-block and an empty region
    drain();
    set_block_count(13'd1);
    push_item(OPC_ACQUIRE, '0, 1'b0);
    push_item(OPC_RELEASE, 12'd0, 1'b1);
    push_item(OPC_ACQUIRE, '0, 1'b0);
    push_item(OPC_ACQUIRE, '0, 1'b0);
    drain();
    set_block_count(13'd0);
    push_item(OPC_ACQUIRE, '0, 1'b0);
    push_item(OPC_RELEASE, '1, 1'b1);
    // count above the store size is clipped
    drain();
    set_block_count('1);
    push_item(OPC_ACQUIRE, '0, 1'b0);
    push_item(OPC_ACQUIRE, '0, 1'b0);
    drain();

    // random phases, each with its own region size and idle rate
    for (int p = 0; p < 8; p++) begin
      set_block_count(counts[p]);
      idle_pct = idles[p];
      run_random(250);
      drain();
    end

    repeat (10) @(negedge clk_i);
    $display("ran %0d items over %0d region sizes: %0d grants, %0d releases, %0d out of memory",
             item_count, cfg_writes, sb.grants, sb.releases, sb.ooms);
    $display("%0d mismatches seen", sb.errors);
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
